[rtl/ovt_pkg.sv]
// Shared command and status codes for the ordered value table engine.
package ovt_pkg;
   localparam int DEPTH = 64;

   typedef enum logic [2:0] {
      KIND_APPEND   = 3'd0,
      KIND_INSERT   = 3'd1,
      KIND_DELETE   = 3'd2,
      KIND_FIND     = 3'd3,
      KIND_CONTAINS = 3'd4,
      KIND_SORT     = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOTFOUND = 2'd2,
      STATUS_BADPOS   = 2'd3
   } status_type;
endpackage

[rtl/ordered_value_table_engine.sv]
// Top level of the ordered value table engine: command sequencer around one RAM.
//
// Keeps a list of up to DEPTH signed 32-bit values plus a count. One request beat
// (req_kind, req_value, req_position) runs one command: append, insert, delete,
// find, contains or sort. Each request yields exactly one response beat with
// status, found, index and the count after the command.
// Handshake: a beat moves on a rising edge where valid is high and stall is low.
// req_stall is high whenever a command is in progress or a response is waiting,
// so only one command is ever in flight; the next request can be taken once the
// response beat has moved.
// Command steps, paced by the single RAM read port:
//   rejected commands, unused kinds: straight to the response; append: write at count.
//   find/contains: entries scanned one by one from the start, read then compare.
//   insert/delete: search (delete), then entries moved one by one, read then write.
//   sort: insertion sort, each outer pass fetching an entry, then compare/move
//   steps until its place is found, where it is then written.
// Reset clears the count and the sequencer; stored entries are not cleared and are
// only ever read below the count. A stalled response holds until taken.
module ordered_value_table_engine
   import ovt_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_kind,
   input  logic signed [31:0]         req_value,
   input  logic [6:0]                 req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_found,
   output logic [5:0]                 rsp_index,
   output logic [6:0]                 rsp_count
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SRD, S_SCMP, S_UPRD, S_UPWR, S_DNRD, S_DNWR,
      S_SOUT, S_SIN, S_SCMPJ, S_SPUT, S_RESP
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   i_ff, i_in;       // scan / move pointer
   logic [CW-1:0]   j_ff, j_in;       // sort inner pointer
   logic [2:0]      kind_ff, kind_in;
   logic [31:0]     val_ff, val_in;
   logic [CW-1:0]   pos_ff, pos_in;
   logic [31:0]     cur_ff, cur_in;   // sort element being placed
   logic [1:0]      status_ff, status_in;
   logic            found_ff, found_in;
   logic [5:0]      index_ff, index_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [31:0]     wr_data, rd_data;

   ovt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic req_take;
   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;

   // sort comparator: signed order test, rd > cur
   logic key_gt;
   assign key_gt = $signed(rd_data) > $signed(cur_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      kind_in      = kind_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      index_in     = index_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = i_ff[AW-1:0];
      wr_data      = val_ff;
      rd_addr      = i_ff[AW-1:0];
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               kind_in   = req_kind;
               val_in    = req_value;
               pos_in    = CW'(req_position);
               status_in = STATUS_OK;
               found_in  = 1'b0;
               index_in  = '0;
               i_in      = '0;
               state_in  = S_RESP;
               unique case (req_kind)
                  KIND_APPEND: begin
                     if (count_ff == CW'(DEPTH)) status_in = STATUS_FULL;
                     else begin
                        i_in     = count_ff;
                        state_in = S_UPRD; // no moves: writes at count at once
                        pos_in   = count_ff;
                     end
                  end
                  KIND_INSERT: begin
                     if (count_ff == CW'(DEPTH)) status_in = STATUS_FULL;
                     else if ({1'b0, req_position} > 8'(count_ff)) status_in = STATUS_BADPOS;
                     else begin
                        i_in     = count_ff;
                        state_in = S_UPRD;
                     end
                  end
                  KIND_DELETE, KIND_FIND, KIND_CONTAINS: state_in = S_SRD;
                  KIND_SORT: begin
                     i_in     = CW'(1);
                     state_in = S_SOUT;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         // linear search: issue read of entry i
         S_SRD: begin
            if (i_ff >= count_ff) begin
               if (kind_ff != KIND_CONTAINS) status_in = STATUS_NOTFOUND;
               state_in = S_RESP;
            end else state_in = S_SCMP;
         end
         S_SCMP: begin
            if (rd_data == val_ff) begin
               if (kind_ff == KIND_DELETE) begin
                  state_in = S_DNRD;
               end else begin
                  found_in = 1'b1;
                  if (kind_ff == KIND_FIND) index_in = 6'(i_ff);
                  state_in = S_RESP;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               rd_addr  = AW'(i_ff + 1'b1);
               state_in = S_SRD;
            end
         end
         // shift up: entry[i] = entry[i-1] while i > pos, then place value
         S_UPRD: begin
            if (i_ff > pos_ff) begin
               rd_addr  = AW'(i_ff - 1'b1);
               state_in = S_UPWR;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[AW-1:0];
               wr_data  = val_ff;
               count_in = count_ff + 1'b1;
               state_in = S_RESP;
            end
         end
         S_UPWR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            i_in     = i_ff - 1'b1;
            state_in = S_UPRD;
         end
         // shift down: entry[i] = entry[i+1] while i+1 < count
         S_DNRD: begin
            if (i_ff + 1'b1 < count_ff) begin
               rd_addr  = AW'(i_ff + 1'b1);
               state_in = S_DNWR;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_RESP;
            end
         end
         S_DNWR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            i_in     = i_ff + 1'b1;
            state_in = S_DNRD;
         end
         // insertion sort outer loop: fetch entry i
         S_SOUT: begin
            if (i_ff >= count_ff) state_in = S_RESP;
            else begin
               state_in = S_SIN;
            end
         end
         S_SIN: begin
            cur_in   = rd_data;
            j_in     = i_ff;
            rd_addr  = AW'(i_ff - 1'b1);
            state_in = S_SCMPJ;
         end
         // rd_data holds entry[j-1]
         S_SCMPJ: begin
            if (key_gt) begin
               wr_en    = 1'b1;
               wr_addr  = j_ff[AW-1:0];
               wr_data  = rd_data;
               j_in     = j_ff - 1'b1;
               if (j_ff == CW'(1)) state_in = S_SPUT;
               else begin
                  rd_addr  = AW'(j_ff - 2'd2);
                  state_in = S_SCMPJ;
               end
            end else state_in = S_SPUT;
         end
         S_SPUT: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[AW-1:0];
            wr_data  = cur_ff;
            i_in     = i_ff + 1'b1;
            rd_addr  = AW'(i_ff + 1'b1);
            state_in = S_SOUT;
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      kind_ff   <= kind_in;
      val_ff    <= val_in;
      pos_ff    <= pos_in;
      cur_ff    <= cur_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      index_ff  <= index_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_found  = found_ff;
   assign rsp_index  = index_ff;
   assign rsp_count  = 7'(count_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("count above capacity");
   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE) else $error("work while response pending");
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && $past(state_ff) == S_IDLE) |-> $stable(count_ff))
      else $error("count changed while idle");
`endif
endmodule

[rtl/ovt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ovt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[sim/ordered_value_table_engine_test.sv]
// Self-checking testbench for the ordered value table engine.
module ordered_value_table_engine_test
   import ovt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 20000000;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [5:0] index;
      logic [6:0] count;
   } table_reply_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_kind = 3'd0;
   logic signed [31:0] req_value = '0;
   logic [6:0]         req_position = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic               rsp_found;
   logic [5:0]         rsp_index;
   logic [6:0]         rsp_count;

   ordered_value_table_engine dut (.*);

   always #4 clock = ~clock;

   // Shadow copy of the table, updated as each beat is accepted.
   logic signed [31:0] shadow_entries [DEPTH];
   int                 shadow_count;
   table_reply_type    pending_replies [$];
   int                 error_count = 0;
   int                 reply_count = 0;
   int                 cycle_count = 0;
   int                 kind_seen [8];
   bit                 hold_off;

   function automatic int shadow_locate(logic signed [31:0] v);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_entries[i] == v) return i;
      return -1;
   endfunction

   // Work out the reply to one command and apply it to the shadow table.
   function automatic table_reply_type apply_command(logic [2:0] kind,
                                                     logic signed [31:0] v,
                                                     logic [6:0] pos);
      table_reply_type r;
      int hit;
      logic signed [31:0] cur;
      int j;
      r = '0;
      case (kind)
         KIND_APPEND: begin
            if (shadow_count >= DEPTH) r.status = STATUS_FULL;
            else begin
               shadow_entries[shadow_count] = v;
               shadow_count++;
            end
         end
         KIND_INSERT: begin
            if (shadow_count >= DEPTH) r.status = STATUS_FULL;
            else if (pos > shadow_count) r.status = STATUS_BADPOS;
            else begin
               for (int k = shadow_count; k > pos; k--) shadow_entries[k] = shadow_entries[k-1];
               shadow_entries[pos] = v;
               shadow_count++;
            end
         end
         KIND_DELETE: begin
            hit = shadow_locate(v);
            if (hit < 0) r.status = STATUS_NOTFOUND;
            else begin
               for (int k = hit; k + 1 < shadow_count; k++) shadow_entries[k] = shadow_entries[k+1];
               shadow_count--;
            end
         end
         KIND_FIND: begin
            hit = shadow_locate(v);
            if (hit < 0) r.status = STATUS_NOTFOUND;
            else begin
               r.found = 1'b1;
               r.index = hit[5:0];
            end
         end
         KIND_CONTAINS: r.found = (shadow_locate(v) >= 0);
         KIND_SORT: begin
            // signed ascending insertion sort
            for (int i = 1; i < shadow_count; i++) begin
               cur = shadow_entries[i];
               j = i;
               while (j > 0 && shadow_entries[j-1] > cur) begin
                  shadow_entries[j] = shadow_entries[j-1];
                  j--;
               end
               shadow_entries[j] = cur;
            end
         end
         default: ;
      endcase
      r.count = shadow_count[6:0];
      return r;
   endfunction

   // Send one command beat; predict when the edge accepts it.
   // Valid stays high after the beat so back-to-back beats need no gap.
   task automatic send_command(logic [2:0] kind, logic signed [31:0] v, logic [6:0] pos);
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_value <= v;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
      pending_replies.push_back(apply_command(kind, v, pos));
      kind_seen[kind]++;
      @(negedge clock);
   endtask

   // Receiver stall: a random stall per beat, or a long hold-off when asked.
   initial begin
      int wait_cycles;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (200) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_off = 1'b0;
         end else if (rsp_valid) begin
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
            if (wait_cycles != 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_cycles) @(negedge clock);
               rsp_stall <= 1'b0;
            end
            @(posedge clock);
         end
      end
   end

   // Reply checker.
   always @(posedge clock) begin
      table_reply_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         reply_count <= reply_count + 1;
         if (pending_replies.size() == 0) begin
            $error("reply beat with nothing expected");
            error_count++;
         end else begin
            e = pending_replies.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d actual %0d", e.status, rsp_status);
               error_count++;
            end
            if (rsp_found !== e.found) begin
               $error("found: expected %0d actual %0d", e.found, rsp_found);
               error_count++;
            end
            if (rsp_index !== e.index) begin
               $error("index: expected %0d actual %0d", e.index, rsp_index);
               error_count++;
            end
            if (rsp_count !== e.count) begin
               $error("count: expected %0d actual %0d", e.count, rsp_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock)
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end

   // A value already stored, or a fresh one when empty.
   function automatic logic signed [31:0] stored_or_random();
      if (shadow_count == 0 || $urandom_range(0, 3) == 0) return $urandom;
      return shadow_entries[$urandom_range(0, shadow_count - 1)];
   endfunction

   task automatic test_directed_edges();
      send_command(KIND_SORT, 0, 0);                    // empty sort
      send_command(KIND_DELETE, 5, 0);                  // delete from empty
      send_command(KIND_FIND, 5, 0);                    // find on empty
      send_command(KIND_INSERT, 7, 7'd1);               // position past count
      send_command(KIND_APPEND, 32'sh7fffffff, 0);
      send_command(KIND_SORT, 0, 0);                    // single entry sort
      send_command(KIND_APPEND, 32'sh80000000, 0);
      send_command(KIND_INSERT, -1, 7'd0);
      send_command(KIND_INSERT, 0, 7'd3);               // insert at end
      send_command(KIND_CONTAINS, 32'sh80000000, 0);
      send_command(KIND_CONTAINS, 12345, 0);
      send_command(KIND_FIND, 0, 0);
      send_command(KIND_APPEND, -1, 0);                 // duplicate
      send_command(KIND_SORT, 0, 0);
      send_command(KIND_FIND, -1, 0);
      send_command(KIND_DELETE, -1, 0);
      send_command(3'd6, 0, 7'd127);                    // unused kinds
      send_command(3'd7, -1, 7'd64);
      send_command(KIND_INSERT, 1, 7'd127);
   endtask

   task automatic test_full_table();
      while (shadow_count < DEPTH) send_command(KIND_APPEND, $urandom, 0);
      send_command(KIND_APPEND, 1, 0);
      send_command(KIND_INSERT, 1, 7'd127);             // full beats bad position
      send_command(KIND_FIND, shadow_entries[DEPTH-1], 0);
      send_command(KIND_SORT, 0, 0);
      send_command(KIND_DELETE, shadow_entries[DEPTH-1], 0);
      send_command(KIND_INSERT, 32'sh55555555, 7'd63);  // refill at the top position
      while (shadow_count > 0) send_command(KIND_DELETE, stored_or_random(), 0);
   endtask

   // Long receiver hold-off while commands keep coming.
   task automatic test_backpressure();
      hold_off = 1'b1;
      for (int i = 0; i < 8; i++) send_command(KIND_APPEND, $urandom, 0);
   endtask

   task automatic test_random_mix(int n);
      int sel;
      logic [6:0] pos;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         // bias toward growing while small, shrinking while near full
         if (sel < 30 - (shadow_count / 4))
            send_command(KIND_APPEND, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) :
                         $urandom, 0);
         else if (sel < 50) begin
            pos = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) :
                  7'($urandom_range(0, shadow_count));
            send_command(KIND_INSERT, $urandom, pos);
         end else if (sel < 68) send_command(KIND_DELETE, stored_or_random(), 0);
         else if (sel < 82) send_command(KIND_FIND, stored_or_random(), 0);
         else if (sel < 93) send_command(KIND_CONTAINS, stored_or_random(), 0);
         else if (sel < 98) send_command(KIND_SORT, $urandom, 7'($urandom_range(0, 127)));
         else send_command(3'($urandom_range(6, 7)), $urandom, 7'($urandom_range(0, 127)));
      end
   endtask

   initial begin
      shadow_count = 0;
      hold_off = 1'b0;
      foreach (shadow_entries[i]) shadow_entries[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_full_table();
      test_backpressure();
      test_random_mix(900);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("covered %0d replies: append %0d insert %0d delete %0d find %0d",
               reply_count, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      $display("contains %0d sort %0d unused kinds %0d, plus full table and hold-off",
               kind_seen[4], kind_seen[5], kind_seen[6] + kind_seen[7]);
      if (error_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
